// ===== rtl/csa_pkg.sv =====
// shared constants, command and status types for the cosine similarity accumulator
`timescale 1ns / 1ps

package csa_pkg;

  // defaults for the top level parameters
  localparam int unsigned VecLenMaxDef = 4096;
  localparam int unsigned ElemWidthDef = 16;

  // fixed field and sum widths
  localparam int unsigned FieldW = 16;
  localparam int unsigned AccW   = 48;
  localparam int unsigned ProdW  = 2 * AccW;
  localparam int unsigned LhsW   = 128;
  localparam int unsigned RhsPad = 32;
  localparam int unsigned MagW   = 15;
  localparam int unsigned OddW   = MagW + 1;
  localparam int unsigned SqW    = 2 * OddW;
  localparam int unsigned BitW   = 4;
  localparam int unsigned StepW  = 6;

  // shift-add step counts, minus one
  localparam logic [StepW-1:0] NormSteps = StepW'(AccW - 1);
  localparam logic [StepW-1:0] LhsSteps  = StepW'(SqW - 1);
  localparam logic [BitW-1:0]  TopBit    = BitW'(MagW - 1);

  // controller states
  typedef enum logic [3:0] {
    S_ACCUM,
    S_LD_P,
    S_MUL_P,
    S_LD_D,
    S_MUL_D,
    S_INIT,
    S_LD_L,
    S_MUL_L,
    S_CMP,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_p;
    logic load_d;
    logic init;
    logic load_l;
    logic step;
    logic cmp;
    logic out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic bit_done;
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/csa_ctrl.sv =====
// controller state machine: accumulate, shift-add multiplies, bit search, result handoff
`timescale 1ns / 1ps

module csa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_i,
  input  csa_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output csa_pkg::cmd_t cmd_o
);

  csa_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csa_pkg::S_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csa_pkg::S_ACCUM: begin
        if (in_valid_i && last_i) state_d = csa_pkg::S_LD_P;
      end
      csa_pkg::S_LD_P:  state_d = csa_pkg::S_MUL_P;
      csa_pkg::S_MUL_P: begin
        if (sts_i.mul_done) state_d = csa_pkg::S_LD_D;
      end
      csa_pkg::S_LD_D:  state_d = csa_pkg::S_MUL_D;
      csa_pkg::S_MUL_D: begin
        if (sts_i.mul_done) state_d = csa_pkg::S_INIT;
      end
      csa_pkg::S_INIT:  state_d = csa_pkg::S_LD_L;
      csa_pkg::S_LD_L:  state_d = csa_pkg::S_MUL_L;
      csa_pkg::S_MUL_L: begin
        if (sts_i.mul_done) state_d = csa_pkg::S_CMP;
      end
      csa_pkg::S_CMP: begin
        state_d = sts_i.bit_done ? csa_pkg::S_OUT : csa_pkg::S_LD_L;
      end
      csa_pkg::S_OUT: begin
        if (!sts_i.out_full) state_d = csa_pkg::S_ACCUM;
      end
      default: state_d = csa_pkg::S_ACCUM;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      csa_pkg::S_ACCUM: begin
        in_stall_o    = 1'b0;
        cmd_o.accept  = in_valid_i;
      end
      csa_pkg::S_LD_P:  cmd_o.load_p = 1'b1;
      csa_pkg::S_LD_D:  cmd_o.load_d = 1'b1;
      csa_pkg::S_INIT:  cmd_o.init   = 1'b1;
      csa_pkg::S_LD_L:  cmd_o.load_l = 1'b1;
      csa_pkg::S_MUL_P,
      csa_pkg::S_MUL_D,
      csa_pkg::S_MUL_L: cmd_o.step   = 1'b1;
      csa_pkg::S_CMP:   cmd_o.cmp    = 1'b1;
      csa_pkg::S_OUT:   cmd_o.out    = !sts_i.out_full;
      default: ;
    endcase
  end

endmodule

// ===== rtl/csa_dp.sv =====
// datapath: running sums, shift-add multiplier, square-root-free bit search, output register
`timescale 1ns / 1ps

module csa_dp #(
  parameter int unsigned VEC_LEN_MAX = csa_pkg::VecLenMaxDef,
  parameter int unsigned ELEM_WIDTH  = csa_pkg::ElemWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [csa_pkg::FieldW-1:0]  elem_a_i,
  input  logic signed [csa_pkg::FieldW-1:0]  elem_b_i,
  input  logic                               last_i,
  input  logic                               out_stall_i,
  input  csa_pkg::cmd_t                      cmd_i,
  output csa_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  output logic signed [csa_pkg::FieldW-1:0]  similarity_o,
  output logic                               zero_norm_o,
  output logic                               overflow_o
);

  localparam int unsigned CntW = $clog2(VEC_LEN_MAX + 1);
  localparam int unsigned EW2  = 2 * ELEM_WIDTH;

  // element extraction: low ELEM_WIDTH bits, sign taken from the top one (a width above FieldW zero-extends)
  logic signed [ELEM_WIDTH-1:0] a_s, b_s;
  if (ELEM_WIDTH <= csa_pkg::FieldW) begin : g_narrow
    assign a_s = elem_a_i[ELEM_WIDTH-1:0];
    assign b_s = elem_b_i[ELEM_WIDTH-1:0];
  end else begin : g_wide
    assign a_s = ELEM_WIDTH'($unsigned(elem_a_i));
    assign b_s = ELEM_WIDTH'($unsigned(elem_b_i));
  end

  // element products
  logic signed [EW2-1:0] prod_ab, prod_aa, prod_bb;
  assign prod_ab = a_s * b_s;
  assign prod_aa = a_s * a_s;
  assign prod_bb = b_s * b_s;

  // running sums
  logic [csa_pkg::AccW-1:0] dot_q, na_sum_q, nb_sum_q;
  logic [csa_pkg::AccW-1:0] dot_n, na_n, nb_n;
  logic [CntW-1:0]          cnt_q;
  logic                     too_long_q;
  logic                     room;

  assign room  = cnt_q < CntW'(VEC_LEN_MAX);
  assign dot_n = room ? dot_q + csa_pkg::AccW'(prod_ab) : dot_q;
  assign na_n  = room ? na_sum_q + csa_pkg::AccW'(prod_aa) : na_sum_q;
  assign nb_n  = room ? nb_sum_q + csa_pkg::AccW'(prod_bb) : nb_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q      <= '0;
      na_sum_q   <= '0;
      nb_sum_q   <= '0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (last_i) begin
        dot_q      <= '0;
        na_sum_q   <= '0;
        nb_sum_q   <= '0;
        cnt_q      <= '0;
        too_long_q <= 1'b0;
      end else if (room) begin
        dot_q    <= dot_n;
        na_sum_q <= na_n;
        nb_sum_q <= nb_n;
        cnt_q    <= cnt_q + 1'b1;
      end else begin
        too_long_q <= 1'b1;
      end
    end
  end

  // snapshot of one finished vector
  logic [csa_pkg::AccW-1:0] na_q, nb_q, mag_q;
  logic                     neg_q, zn_q, ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_i) begin
      na_q  <= na_n;
      nb_q  <= nb_n;
      neg_q <= dot_n[csa_pkg::AccW-1];
      mag_q <= dot_n[csa_pkg::AccW-1] ? -dot_n : dot_n;
      zn_q  <= (na_n == '0) || (nb_n == '0);
      ovf_q <= too_long_q || !room;
    end
  end

  // search candidate and its odd square
  logic [csa_pkg::MagW-1:0] r_q, cand;
  logic [csa_pkg::BitW-1:0] bit_q;
  logic [csa_pkg::OddW-1:0] odd;
  logic [csa_pkg::SqW-1:0]  odd_sq;

  assign cand   = r_q | (csa_pkg::MagW'(1) << bit_q);
  assign odd    = {cand, 1'b0} - 1'b1;
  assign odd_sq = odd * odd;

  // shift-add multiplier, one multiplier bit per cycle
  logic [csa_pkg::LhsW-1:0]  mcand_q, acc_q;
  logic [csa_pkg::AccW-1:0]  mplier_q;
  logic [csa_pkg::StepW-1:0] step_q;
  logic [csa_pkg::ProdW-1:0] p_q, dsq_q;
  logic                      lhs_le;

  assign lhs_le = acc_q <= {dsq_q, {csa_pkg::RhsPad{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_p) begin
      mcand_q  <= csa_pkg::LhsW'(na_q);
      mplier_q <= nb_q;
      acc_q    <= '0;
      step_q   <= csa_pkg::NormSteps;
    end else if (cmd_i.load_d) begin
      p_q      <= acc_q[csa_pkg::ProdW-1:0];
      mcand_q  <= csa_pkg::LhsW'(mag_q);
      mplier_q <= mag_q;
      acc_q    <= '0;
      step_q   <= csa_pkg::NormSteps;
    end else if (cmd_i.load_l) begin
      mcand_q  <= csa_pkg::LhsW'(p_q);
      mplier_q <= csa_pkg::AccW'(odd_sq);
      acc_q    <= '0;
      step_q   <= csa_pkg::LhsSteps;
    end else if (cmd_i.step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      step_q   <= step_q - 1'b1;
    end
  end

  // bit search over the result magnitude, top bit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      dsq_q <= acc_q[csa_pkg::ProdW-1:0];
      r_q   <= '0;
      bit_q <= csa_pkg::TopBit;
    end else if (cmd_i.cmp) begin
      if (lhs_le) r_q <= cand;
      bit_q <= bit_q - 1'b1;
    end
  end

  // output register
  logic                              out_valid_q;
  logic signed [csa_pkg::FieldW-1:0] sim_q;
  logic                              zn_out_q, ovf_out_q;
  logic [csa_pkg::FieldW-1:0]        r_ext;

  assign r_ext = csa_pkg::FieldW'(r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      if (zn_q) begin
        sim_q <= '0;
      end else begin
        sim_q <= neg_q ? -r_ext : r_ext;
      end
      zn_out_q  <= zn_q;
      ovf_out_q <= ovf_q;
    end
  end

  // status
  assign sts_o.mul_done = step_q == '0;
  assign sts_o.bit_done = bit_q == '0;
  assign sts_o.out_full = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zn_out_q;
  assign overflow_o   = ovf_out_q;

endmodule

// ===== rtl/cosine_similarity_accumulator.sv =====
// top level: cosine similarity of two streamed vectors in signed Q1.15
//
// channel  direction  handshake                 words
// input    in         in_valid_i / in_stall_o   elem_a_i, elem_b_i, last_i
// output   out        out_valid_o / out_stall_i similarity_o, zero_norm_o, overflow_o
//
// while accumulating, one element pair is taken every cycle (multiply-add of three sums)
// after the word marked last the input stalls while the shift-add multiplies run one
// bit per cycle through a 128-bit adder: norm product, dot square, one per search bit
// the result sits in an output register; a held result only stalls the next vector end
// rst_ni clears the sums, the pair count and the output valid asynchronously
`timescale 1ns / 1ps

module cosine_similarity_accumulator #(
  parameter int unsigned VEC_LEN_MAX = csa_pkg::VecLenMaxDef,
  parameter int unsigned ELEM_WIDTH  = csa_pkg::ElemWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [csa_pkg::FieldW-1:0] elem_a_i,
  input  logic signed [csa_pkg::FieldW-1:0] elem_b_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [csa_pkg::FieldW-1:0] similarity_o,
  output logic                              zero_norm_o,
  output logic                              overflow_o
);

  csa_pkg::cmd_t cmd;
  csa_pkg::sts_t sts;

  // sequencer
  csa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // arithmetic
  csa_dp #(
    .VEC_LEN_MAX (VEC_LEN_MAX),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .last_i       (last_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ===== rtl/csa_chk.sv =====
// port-level checker for the cosine similarity accumulator, bound to the top level
`timescale 1ns / 1ps

module csa_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic signed [csa_pkg::FieldW-1:0] elem_a_i,
  input logic signed [csa_pkg::FieldW-1:0] elem_b_i,
  input logic                              last_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [csa_pkg::FieldW-1:0] similarity_o,
  input logic                              zero_norm_o,
  input logic                              overflow_o
);

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(similarity_o)
      && $stable(zero_norm_o) && $stable(overflow_o))
    else $error("result word changed while stalled");

  // a zero norm forces a zero similarity
  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> similarity_o == '0)
    else $error("zero norm with nonzero similarity");

  // the 15-bit result magnitude keeps the similarity within 32767, so -32768 never appears
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> similarity_o != {1'b1, {(csa_pkg::FieldW-1){1'b0}}})
    else $error("similarity outside symmetric range");

  // the end of a vector starts the final computation, so input stalls
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after last word");

  // a long computation separates the last word and its result
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> ##1 !$rose(out_valid_o))
    else $error("result appeared too soon after last word");

endmodule

bind cosine_similarity_accumulator csa_chk u_csa_chk (.*);

// ===== tb/cosine_similarity_accumulator_tb.sv =====
// self-checking testbench for the cosine similarity accumulator, with an exact integer predictor
`timescale 1ns / 1ps

module cosine_similarity_accumulator_tb;

  localparam int unsigned VecLenMax  = csa_pkg::VecLenMaxDef;
  localparam int unsigned AccW       = csa_pkg::AccW;
  localparam int unsigned FieldW     = csa_pkg::FieldW;
  // about 1550 pairs; even if every pair ended a vector, the run stays well below this
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned TailCycles = 700;
  localparam int unsigned MaxReports = 10;

  typedef logic signed [FieldW-1:0] elem_t;

  typedef struct {
    logic [FieldW-1:0] similarity;
    logic              zero_norm;
    logic              overflow;
  } cos_result_t;

  // how a random vector pair relates its two halves
  typedef enum {
    V_INDEP,
    V_PARALLEL,
    V_OPPOSITE,
    V_NEAR,
    V_ZERO_A,
    V_ZERO_B,
    V_SPARSE
  } vec_shape_e;

  // element value ranges
  typedef enum {
    MAG_FULL,
    MAG_SMALL,
    MAG_EDGE
  } mag_range_e;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  elem_t elem_a_i    = '0;
  elem_t elem_b_i    = '0;
  logic  last_i      = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  elem_t similarity_o;
  logic  zero_norm_o;
  logic  overflow_o;

  // predictor state: running sums of the vector in flight
  logic [AccW-1:0] acc_dot   = '0;
  logic [AccW-1:0] acc_norm_a = '0;
  logic [AccW-1:0] acc_norm_b = '0;
  int unsigned     acc_pairs = 0;
  logic            acc_dropped = 1'b0;

  cos_result_t expected_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned pairs_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned zero_norm_seen = 0;
  int unsigned overflow_seen  = 0;

  cosine_similarity_accumulator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o),
    .overflow_o   (overflow_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // largest r with (2r-1)^2 * na * nb <= mag^2 * 2^32, signed by the dot sum
  function automatic logic [FieldW-1:0] cos_q15(input logic [AccW-1:0] dot,
                                                input logic [AccW-1:0] na,
                                                input logic [AccW-1:0] nb);
    logic [159:0]    norm_prod;
    logic [159:0]    rhs;
    logic [159:0]    lhs;
    logic [AccW-1:0] mag;
    logic [14:0]     r;
    logic [14:0]     cand;
    logic [15:0]     odd;
    logic            neg;
    neg       = dot[AccW-1];
    mag       = neg ? -dot : dot;
    norm_prod = 160'(na) * 160'(nb);
    rhs       = (160'(mag) * 160'(mag)) << 32;
    r         = '0;
    for (int bit_i = 14; bit_i >= 0; bit_i--) begin
      cand = r | (15'd1 << bit_i);
      odd  = {cand, 1'b0} - 16'd1;
      lhs  = 160'(odd) * 160'(odd) * norm_prod;
      if (lhs <= rhs) r = cand;
    end
    return neg ? -{1'b0, r} : {1'b0, r};
  endfunction

  function automatic elem_t rand_elem(input mag_range_e range_sel);
    case (range_sel)
      MAG_FULL:  return elem_t'($urandom());
      MAG_SMALL: return elem_t'($urandom_range(1023)) - elem_t'(512);
      default: begin
        case ($urandom_range(4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return '0;
          3:       return 16'sh0001;
          default: return 16'shFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch in result %0d: %s expected %0d got %0d", results_seen, what, want,
               got);
  endfunction

  // one element pair; the predictor advances when the word is taken
  task automatic send_pair(input elem_t a, input elem_t b, input logic is_last);
    logic signed [31:0] prod_ab;
    logic signed [31:0] prod_aa;
    logic signed [31:0] prod_bb;
    cos_result_t        want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    elem_a_i   <= a;
    elem_b_i   <= b;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pairs_sent++;
    // pairs past the length limit leave the sums alone
    if (acc_pairs < VecLenMax) begin
      prod_ab    = a * b;
      prod_aa    = a * a;
      prod_bb    = b * b;
      acc_dot    = acc_dot + {{(AccW-32){prod_ab[31]}}, prod_ab};
      acc_norm_a = acc_norm_a + {{(AccW-32){prod_aa[31]}}, prod_aa};
      acc_norm_b = acc_norm_b + {{(AccW-32){prod_bb[31]}}, prod_bb};
      acc_pairs++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (is_last) begin
      want.zero_norm  = (acc_norm_a == '0) || (acc_norm_b == '0);
      want.similarity = want.zero_norm ? '0 : cos_q15(acc_dot, acc_norm_a, acc_norm_b);
      want.overflow   = acc_dropped;
      expected_q.insert(expected_q.size(), want);
      acc_dot     = '0;
      acc_norm_a  = '0;
      acc_norm_b  = '0;
      acc_pairs   = 0;
      acc_dropped = 1'b0;
    end
  endtask

  // lower valid and wait until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    cos_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result word: similarity %0d zero_norm %0b overflow %0b",
                   similarity_o, zero_norm_o, overflow_o);
      end else begin
        want = expected_q.pop_front();
        if (want.zero_norm) zero_norm_seen++;
        if (want.overflow) overflow_seen++;
        if (similarity_o !== want.similarity)
          flag_mismatch("similarity", $signed(want.similarity), similarity_o);
        if (zero_norm_o !== want.zero_norm)
          flag_mismatch("zero_norm", want.zero_norm, zero_norm_o);
        if (overflow_o !== want.overflow)
          flag_mismatch("overflow", want.overflow, overflow_o);
      end
    end
  end

  // extremes, zero norms, exact angles and both signs
  task automatic test_directed();
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh5555, 16'shAAAA, 1'b1);
    send_pair(16'sh0001, 16'shFFFF, 1'b1);
    // zero first vector, zero second vector, both zero
    send_pair(16'sh0000, 16'sh007B, 1'b0);
    send_pair(16'sh0000, 16'shFFF9, 1'b1);
    send_pair(16'sh012C, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    // orthogonal, then 45 degrees
    send_pair(16'sh0100, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0100, 1'b1);
    send_pair(16'sh0100, 16'sh0100, 1'b0);
    send_pair(16'sh0000, 16'sh0100, 1'b1);
    // dot product cancels to zero
    send_pair(16'shFFFF, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh0001, 1'b1);
    // largest negative cross products
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    wait_drained();
  endtask

  // random vectors of mostly short length with related or unrelated halves
  task automatic test_random_vectors(input int unsigned n_pairs);
    int unsigned sent;
    int unsigned len;
    int unsigned shape_pick;
    vec_shape_e  shape;
    mag_range_e  range_sel;
    elem_t       a;
    elem_t       b;
    sent = 0;
    while (sent < n_pairs) begin
      len        = ($urandom_range(15) == 0) ? $urandom_range(13, 160) : $urandom_range(1, 12);
      shape_pick = $urandom_range(9);
      shape      = (shape_pick > V_SPARSE) ? V_INDEP : vec_shape_e'(shape_pick);
      range_sel  = mag_range_e'($urandom_range(2));
      for (int i = 0; i < len; i++) begin
        a = rand_elem(range_sel);
        case (shape)
          V_PARALLEL: b = a;
          V_OPPOSITE: b = -a;
          V_NEAR:     b = a + elem_t'($urandom_range(64)) - elem_t'(32);
          V_ZERO_A: begin
            b = a;
            a = '0;
          end
          V_ZERO_B:   b = '0;
          V_SPARSE: begin
            if ($urandom_range(3) != 0) a = '0;
            b = ($urandom_range(3) != 0) ? elem_t'(0) : rand_elem(range_sel);
          end
          default:    b = rand_elem(range_sel);
        endcase
        send_pair(a, b, i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  // receiver holds off long enough that the output register fills and the input stalls
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_cycles = 2500;
    for (int v = 0; v < 5; v++) begin
      for (int i = 0; i < 3; i++)
        send_pair(rand_elem(MAG_FULL), rand_elem(MAG_FULL), i == 2);
    end
    wait_drained();
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 22;
    recv_stall_pct = 71;
    test_directed();
    test_random_vectors(510);

    send_idle_pct  = 71;
    recv_stall_pct = 22;
    test_backpressure();
    test_random_vectors(510);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_vectors(500);

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d element pairs in %0d vectors: %0d zero-norm, %0d over-length",
             pairs_sent, results_seen, zero_norm_seen, overflow_seen);
    $display("three idle mixes plus a long output hold-off; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== cosine_similarity_accumulator.f =====
rtl/csa_pkg.sv
rtl/csa_ctrl.sv
rtl/csa_dp.sv
rtl/cosine_similarity_accumulator.sv
rtl/csa_chk.sv
tb/cosine_similarity_accumulator_tb.sv
